// File: rtl/rim_pkg.sv
`timescale 1ns / 1ps

package rim_pkg;

   // sizing
   localparam int MAX_SEGMENTS = 64;
   localparam int TIME_BITS    = 44;
   localparam int GAP_BITS     = 32;
   localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);

   // cell operations
   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_SHIFT  = 2'd2;

   typedef logic [TIME_BITS-1:0] time_type;

   // broadcast to every cell
   typedef struct packed {
      logic [1:0] op;
      time_type   start;
      time_type   stop;
   } cell_cmd_type;

   // one merged run leaving the walk unit
   typedef struct packed {
      logic     valid;
      time_type start;
      time_type stop;
      logic     last;
   } run_word_type;

endpackage

// File: rtl/rim_cell.sv
`timescale 1ns / 1ps

module rim_cell (
   input  logic                  clock,
   input  rim_pkg::cell_cmd_type cmd,
   input  logic                  valid,
   input  logic                  prev_mine,
   input  rim_pkg::time_type     prev_start,
   input  rim_pkg::time_type     prev_stop,
   input  rim_pkg::time_type     next_start,
   input  rim_pkg::time_type     next_stop,
   output logic                  mine,
   output rim_pkg::time_type     start,
   output rim_pkg::time_type     stop
);

   rim_pkg::time_type start_ff, start_in;
   rim_pkg::time_type stop_ff, stop_in;

   // new word goes at or before this cell; equal starts stay behind
   assign mine = !valid || (start_ff > cmd.start);

   // take new word, shift up from the left, or shift down from the right
   always_comb begin
      start_in = start_ff;
      stop_in  = stop_ff;
      case (cmd.op)
         rim_pkg::OP_INSERT: begin
            if (mine && prev_mine) begin
               start_in = prev_start;
               stop_in  = prev_stop;
            end else if (mine) begin
               start_in = cmd.start;
               stop_in  = cmd.stop;
            end
         end
         rim_pkg::OP_SHIFT: begin
            start_in = next_start;
            stop_in  = next_stop;
         end
         default: begin
            start_in = start_ff;
            stop_in  = stop_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      stop_ff  <= stop_in;
   end

   assign start = start_ff;
   assign stop  = stop_ff;

endmodule

// File: rtl/rim_merge.sv
`timescale 1ns / 1ps

module rim_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        active,
   input  logic                        has_more,
   input  rim_pkg::time_type           head_start,
   input  rim_pkg::time_type           head_stop,
   input  logic [rim_pkg::GAP_BITS-1:0] gap,
   input  logic                        out_free,
   output logic                        consume,
   output logic                        done,
   output rim_pkg::run_word_type       run
);

   rim_pkg::time_type rs_ff, rs_in;
   rim_pkg::time_type re_ff, re_in;
   logic              have_ff, have_in;
   logic              joins;
   rim_pkg::time_type diff;

   // join test against the open run
   assign diff  = head_start - re_ff;
   assign joins = (head_start <= re_ff) || (diff <= rim_pkg::TIME_BITS'(gap));

   // walk one stored segment per cycle, except while a run must leave and out_free is low
   always_comb begin
      rs_in     = rs_ff;
      re_in     = re_ff;
      have_in   = have_ff;
      consume   = 1'b0;
      done      = 1'b0;
      run.valid = 1'b0;
      run.start = rs_ff;
      run.stop  = re_ff;
      run.last  = 1'b0;
      if (active) begin
         if (has_more) begin
            if (!have_ff) begin
               consume = 1'b1;
               rs_in   = head_start;
               re_in   = head_stop;
               have_in = 1'b1;
            end else if (joins) begin
               consume = 1'b1;
               if (head_stop > re_ff) begin
                  re_in = head_stop;
               end
            end else if (out_free) begin
               run.valid = 1'b1;
               consume   = 1'b1;
               rs_in     = head_start;
               re_in     = head_stop;
            end
         end else if (have_ff) begin
            if (out_free) begin
               run.valid = 1'b1;
               run.last  = 1'b1;
               have_in   = 1'b0;
               done      = 1'b1;
            end
         end else begin
            done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
      rs_ff <= rs_in;
      re_ff <= re_in;
   end

endmodule

// File: rtl/recording_interval_merge.sv
`timescale 1ns / 1ps

// Merges a set of time segments into runs.
// req_ channel: one segment word (start, end, set_last) per accepted cycle.
//    Segments are sorted on arrival by a row of cells, one word per cycle;
//    equal starts keep arrival order. Past capacity a word is dropped and
//    the set is flagged as overflowed.
// After the set_last word the row drains through the walk unit at the head:
//    one stored segment per cycle, then one cycle for the final run, so a
//    set of n segments takes n + 1 cycles before req_stall falls, plus any
//    cycles the receiver stalls a run that must leave. req_stall is high
//    during the whole drain.
// rsp_ channel: one word per merged run, rsp_run_last on the final one,
//    rsp_overflowed the same on every run of the set. An output register
//    holds a stalled word; the walk waits only when a run must be emitted
//    while that register is still occupied.
// csr_ channel: writes gap_ms, always ready; write only while idle.
// Reset (synchronous): empties the row, clears the overflow flag and the
//    output register, sets gap_ms to 0.

module recording_interval_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rim_pkg::TIME_BITS-1:0] req_seg_start,
   input  logic [rim_pkg::TIME_BITS-1:0] req_seg_end,
   input  logic                          req_set_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rim_pkg::TIME_BITS-1:0] rsp_run_start,
   output logic [rim_pkg::TIME_BITS-1:0] rsp_run_end,
   output logic                          rsp_run_last,
   output logic                          rsp_overflowed,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rim_pkg::GAP_BITS-1:0]  csr_gap_ms
);

   localparam logic ST_LOAD  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic                          state_ff, state_in;
   logic [rim_pkg::CNT_BITS-1:0]  count_ff, count_in;
   logic                          ovf_ff, ovf_in;
   logic [rim_pkg::GAP_BITS-1:0]  gap_ff;
   logic                          accept, full, out_free, consume, done;
   rim_pkg::cell_cmd_type         cmd;
   rim_pkg::run_word_type         run;

   logic [rim_pkg::MAX_SEGMENTS-1:0] mine;
   rim_pkg::time_type                cell_start [rim_pkg::MAX_SEGMENTS];
   rim_pkg::time_type                cell_stop  [rim_pkg::MAX_SEGMENTS];

   logic                          rsp_valid_ff;
   rim_pkg::time_type             rsp_start_ff, rsp_end_ff;
   logic                          rsp_last_ff, rsp_ovf_ff;

   assign req_stall = (state_ff != ST_LOAD);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == rim_pkg::CNT_BITS'(rim_pkg::MAX_SEGMENTS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // command to the row
   always_comb begin
      cmd.op    = rim_pkg::OP_HOLD;
      cmd.start = req_seg_start;
      cmd.stop  = req_seg_end;
      if (accept && !full) begin
         cmd.op = rim_pkg::OP_INSERT;
      end else if (consume) begin
         cmd.op = rim_pkg::OP_SHIFT;
      end
   end

   // row of sorting cells
   for (genvar i = 0; i < rim_pkg::MAX_SEGMENTS; i++) begin : g_cell
      logic              prev_mine;
      rim_pkg::time_type prev_start, prev_stop, next_start, next_stop;
      if (i == 0) begin : g_first
         assign prev_mine  = 1'b0;
         assign prev_start = '0;
         assign prev_stop  = '0;
      end else begin : g_mid
         assign prev_mine  = mine[i-1];
         assign prev_start = cell_start[i-1];
         assign prev_stop  = cell_stop[i-1];
      end
      if (i == rim_pkg::MAX_SEGMENTS - 1) begin : g_tail
         assign next_start = cell_start[i];
         assign next_stop  = cell_stop[i];
      end else begin : g_body
         assign next_start = cell_start[i+1];
         assign next_stop  = cell_stop[i+1];
      end
      rim_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .valid      (count_ff > rim_pkg::CNT_BITS'(i)),
         .prev_mine  (prev_mine),
         .prev_start (prev_start),
         .prev_stop  (prev_stop),
         .next_start (next_start),
         .next_stop  (next_stop),
         .mine       (mine[i]),
         .start      (cell_start[i]),
         .stop       (cell_stop[i])
      );
   end

   // walk unit at the head of the row
   rim_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .active     (state_ff == ST_DRAIN),
      .has_more   (count_ff != '0),
      .head_start (cell_start[0]),
      .head_stop  (cell_stop[0]),
      .gap        (gap_ff),
      .out_free   (out_free),
      .consume    (consume),
      .done       (done),
      .run        (run)
   );

   // load / drain control
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
               if (req_set_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (consume) begin
               count_in = count_ff - 1'b1;
            end
            if (done) begin
               state_in = ST_LOAD;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         gap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         if (csr_valid && csr_ready) begin
            gap_ff <= csr_gap_ms;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= run.valid;
      end
      if (out_free && run.valid) begin
         rsp_start_ff <= run.start;
         rsp_end_ff   <= run.stop;
         rsp_last_ff  <= run.last;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_run_start  = rsp_start_ff;
   assign rsp_run_end    = rsp_end_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_overflowed = rsp_ovf_ff;

endmodule

// File: rtl/rim_checker.sv
`timescale 1ns / 1ps

module rim_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [rim_pkg::TIME_BITS-1:0] rsp_run_start,
   input logic                          rsp_run_last
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_run_start))
      else $error("stalled result word changed");

   // a non-final run means the set is still draining
   a_drain_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> req_stall)
      else $error("input taken while runs of a set are pending");

endmodule

bind recording_interval_merge rim_checker u_rim_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_run_start (rsp_run_start),
   .rsp_run_last  (rsp_run_last)
);

// File: tb/sv/recording_interval_merge_tb.sv
`timescale 1ns / 1ps

module recording_interval_merge_tb;
   import rim_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int QUIET_CYCLES = MAX_SEGMENTS + 8;
   localparam int LONG_HOLD    = 400;
   localparam int REPORT_LIMIT = 10;

   localparam time_type            TIME_MAX = '1;
   localparam logic [GAP_BITS-1:0] GAP_MAX  = '1;

   // one merged run as seen on the rsp_ channel
   typedef struct packed {
      time_type start;
      time_type stop;
      logic     last;
      logic     dropped;
   } rsp_word_type;

   // sorts each set as it arrives and works out its merged runs on set_last
   class merge_tracker;
      time_type            starts[$];
      time_type            ends[$];
      bit                  dropped = 1'b0;
      logic [GAP_BITS-1:0] gap_ms = '0;
      rsp_word_type        runs_due[$];
      int                  errors = 0;

      function void note_segment(time_type s, time_type e, logic last);
         int       pos;
         int       i;
         time_type run_start;
         time_type run_end;
         // sorted insert, equal starts stay in arrival order
         if (starts.size() >= MAX_SEGMENTS) begin
            dropped = 1'b1;
         end else begin
            pos = 0;
            while (pos < starts.size() && starts[pos] <= s) pos++;
            starts.insert(pos, s);
            ends.insert(pos, e);
         end
         if (!last) return;
         // walk the set in start order
         run_start = '0;
         run_end   = '0;
         for (i = 0; i < starts.size(); i++) begin
            if (i > 0 && (starts[i] <= run_end ||
                          starts[i] - run_end <= time_type'(gap_ms))) begin
               if (ends[i] > run_end) run_end = ends[i];
            end else begin
               if (i > 0) runs_due.push_back('{run_start, run_end, 1'b0, dropped});
               run_start = starts[i];
               run_end   = ends[i];
            end
         end
         if (starts.size() > 0) runs_due.push_back('{run_start, run_end, 1'b1, dropped});
         starts.delete();
         ends.delete();
         dropped = 1'b0;
      endfunction

      function void check_run(rsp_word_type got);
         rsp_word_type want;
         if (runs_due.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: unexpected run start %h end %h last %b ovf %b",
                        $time, got.start, got.stop, got.last, got.dropped);
            return;
         end
         want = runs_due.pop_front();
         if (got.start !== want.start || got.stop !== want.stop ||
             got.last !== want.last || got.dropped !== want.dropped) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: mismatch, want %h..%h last %b ovf %b, got %h..%h last %b ovf %b",
                        $time, want.start, want.stop, want.last, want.dropped,
                        got.start, got.stop, got.last, got.dropped);
         end
      endfunction
   endclass

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   time_type            req_seg_start  = '0;
   time_type            req_seg_end    = '0;
   logic                req_set_last   = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   time_type            rsp_run_start;
   time_type            rsp_run_end;
   logic                rsp_run_last;
   logic                rsp_overflowed;
   logic                csr_valid      = 1'b0;
   logic                csr_ready;
   logic [GAP_BITS-1:0] csr_gap_ms     = '0;

   merge_tracker tracker;
   int           segments_sent = 0;
   int           cycle_count   = 0;
   int           rsp_wait_left = 0;
   bit           rsp_eager     = 1'b0;
   bit           req_eager     = 1'b0;
   bit           hold_go       = 1'b0;
   logic         long_hold     = 1'b0;

   recording_interval_merge dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_seg_start  (req_seg_start),
      .req_seg_end    (req_seg_end),
      .req_set_last   (req_set_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_run_start  (rsp_run_start),
      .rsp_run_end    (rsp_run_end),
      .rsp_run_last   (rsp_run_last),
      .rsp_overflowed (rsp_overflowed),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_gap_ms     (csr_gap_ms)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side: check each accepted word, then draw a random stall for the next word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_run('{rsp_run_start, rsp_run_end, rsp_run_last, rsp_overflowed});
         if ($urandom_range(0, 15) == 0) rsp_eager = !rsp_eager;
         rsp_wait_left = rsp_eager ? 0 : $urandom_range(0, 7);
      end else if (rsp_valid && rsp_wait_left > 0) begin
         rsp_wait_left--;
      end
      rsp_stall <= long_hold || rsp_wait_left != 0;
   end

   // long receiver hold-off so the drain stalls and req_stall backs up
   initial begin
      wait (hold_go);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      long_hold <= 1'b0;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   function automatic time_type any_time();
      longint unsigned r;
      r = {$urandom, $urandom};
      return r[TIME_BITS-1:0];
   endfunction

   function automatic time_type near_time(time_type base, longint unsigned spread);
      longint unsigned r;
      r = {$urandom, $urandom};
      return time_type'(base + r % (spread + 1));
   endfunction

   // mostly small sets, some medium, a few around capacity
   function automatic int pick_set_size();
      case ($urandom_range(0, 19))
         0: return $urandom_range(MAX_SEGMENTS - 2, MAX_SEGMENTS + 6);
         1, 2: return $urandom_range(9, 40);
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   // offer one segment word and hold it until accepted
   task automatic send_segment(time_type s, time_type e, logic last);
      int idle;
      idle = req_eager ? 0 : $urandom_range(0, 7);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_seg_start <= s;
      req_seg_end   <= e;
      req_set_last  <= last;
      do begin
         @(posedge clock);
      end while (req_stall);
      tracker.note_segment(s, e, last);
      segments_sent++;
   endtask

   // stop offering and wait until every run of the sent sets is back
   task automatic drain_runs();
      req_valid <= 1'b0;
      while (tracker.runs_due.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_gap(logic [GAP_BITS-1:0] value);
      csr_valid  <= 1'b1;
      csr_gap_ms <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.gap_ms = value;
   endtask

   // clustered segments around a random base, sometimes pure noise
   task automatic send_random_set(int count);
      int              i;
      time_type        base;
      time_type        s;
      time_type        e;
      longint unsigned spread;
      bit              noise;
      base  = any_time();
      noise = $urandom_range(0, 4) == 0;
      case ($urandom_range(0, 4))
         0: spread = 0;
         1: spread = 64;
         2: spread = 5000;
         3: spread = 64'd1 << 24;
         default: spread = 64'd1 << 34;
      endcase
      if ($urandom_range(0, 7) == 0) req_eager = !req_eager;
      for (i = 0; i < count; i++) begin
         if (noise) begin
            s = any_time();
            e = any_time();
         end else begin
            s = near_time(base, spread);
            if ($urandom_range(0, 15) == 0) e = s - time_type'($urandom_range(1, 100));
            else e = near_time(s, spread);
         end
         send_segment(s, e, i == count - 1);
      end
   endtask

   task automatic run_phase(int quota);
      int target;
      target = segments_sent + quota;
      while (segments_sent < target) begin
         send_random_set(pick_set_size());
         if ($urandom_range(0, 9) == 0) drain_runs();
      end
   endtask

   initial begin
      tracker = new;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single segments at both ends of the time range
      send_segment('0, '0, 1'b1);
      send_segment(TIME_MAX, TIME_MAX, 1'b1);
      // widest segment, and one ending before its start
      send_segment('0, TIME_MAX, 1'b0);
      send_segment(TIME_MAX, '0, 1'b1);
      // out of order arrival, equal starts, end before start
      send_segment(10, 20, 1'b0);
      send_segment(5, 8, 1'b0);
      send_segment(5, 30, 1'b0);
      send_segment(40, 35, 1'b0);
      send_segment(21, 22, 1'b1);
      // touching joins at gap zero, one apart does not
      send_segment(100, 200, 1'b0);
      send_segment(200, 250, 1'b0);
      send_segment(251, 260, 1'b1);
      drain_runs();

      write_gap(1);
      send_segment(201, 300, 1'b0);
      send_segment(100, 200, 1'b1);
      send_segment(400, 500, 1'b0);
      send_segment(502, 600, 1'b1);
      drain_runs();

      // largest gap merges exactly at its limit
      write_gap(GAP_MAX);
      send_segment('0, '0, 1'b0);
      send_segment(time_type'(GAP_MAX), 5, 1'b0);
      send_segment(TIME_MAX, TIME_MAX, 1'b1);
      drain_runs();

      // random sets under several gap settings
      run_phase(100);
      drain_runs();
      write_gap('0);
      send_random_set(MAX_SEGMENTS + 3);
      run_phase(100);
      drain_runs();
      write_gap($urandom_range(1, 3000));
      hold_go = 1'b1;
      run_phase(100);
      drain_runs();
      write_gap($urandom);
      run_phase(100);
      drain_runs();

      if (tracker.errors == 0 && tracker.runs_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
